FILE: hdl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and the message-index helper function of the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_PRIME,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } md5_state_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } md5_words_type;

   localparam logic REQ_ABSORB = 1'b0;
   localparam logic REQ_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   localparam md5_words_type CHAIN_INIT = '{
      a: 32'h67452301,
      b: 32'hefcdab89,
      c: 32'h98badcfe,
      d: 32'h10325476
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   // message word used by a round
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] r;
      logic [3:0] idx;
      r = rnd[3:0];
      case (rnd[5:4])
         2'd0:    idx = r;
         2'd1:    idx = 4'((r << 2) + r + 4'd1);
         2'd2:    idx = 4'((r << 1) + r + 4'd5);
         2'd3:    idx = 4'((r << 3) - r);
         default: idx = r;
      endcase
      return idx;
   endfunction

endpackage

FILE: hdl/md5_ram.sv
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module md5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/md5_round.sv
// ----------------------------------------------------------------------------
// md5_round
// One MD5 step: round function, additions, rotation; gives the new B word.
// ----------------------------------------------------------------------------
module md5_round
   import md5_pkg::*;
(
   input  md5_words_type work,
   input  logic [5:0]    rnd,
   input  logic [31:0]   msg_word,
   output logic [31:0]   new_b
);

   logic [31:0] f_val;
   logic [31:0] sum;
   logic [4:0]  shamt;
   logic [63:0] rot_wide;

   always_comb begin
      case (rnd[5:4])
         2'd0:    f_val = (work.b & work.c) | (~work.b & work.d);
         2'd1:    f_val = (work.b & work.d) | (work.c & ~work.d);
         2'd2:    f_val = work.b ^ work.c ^ work.d;
         2'd3:    f_val = work.c ^ (work.b | ~work.d);
         default: f_val = work.b ^ work.c ^ work.d;
      endcase
   end

   assign sum      = work.a + f_val + msg_word + ROUND_CONST[rnd];
   assign shamt    = ROT_AMOUNT[{rnd[5:4], rnd[1:0]}];
   assign rot_wide = {sum, sum} << shamt;
   assign new_b    = rot_wide[63:32] + work.b;

endmodule

FILE: hdl/md5_stream_hasher.sv
// ----------------------------------------------------------------------------
// md5_stream_hasher
// Byte-serial MD5: absorbs one message byte per request, digests on finish.
// ----------------------------------------------------------------------------
// Block end: the byte that fills a block holds off input through a read
//   prime, 64 rounds and a chain add.
// Finish: pad-word write, zero fill of the rest of the block, then
//   compression; a spill block adds a full zero fill and a second
//   compression; then the digest is loaded once the response slot is free.
//   The compression runs its rounds in order over the block RAM.
// Throughput: 1 byte per cycle between block boundaries.
// Reset: synchronous, active high; chain words to MD5 init, bit count to 0.
module md5_stream_hasher
   import md5_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word0,
   output logic [31:0] rsp_digest_word1,
   output logic [31:0] rsp_digest_word2,
   output logic [31:0] rsp_digest_word3
);

   // control state
   md5_state_type state_ff, state_in;
   logic          fin_ff, fin_in;     // finish sequence in progress
   logic          two_ff, two_in;     // padding spills into an extra block
   logic          rsp_valid_ff, rsp_valid_in;

   // hash state
   md5_words_type chain_ff, chain_in;
   logic [63:0]   bit_count_ff, bit_count_in;

   // working registers
   md5_words_type work_ff, work_in;
   md5_words_type digest_ff, digest_in;
   logic [23:0]   acc_ff, acc_in;     // low bytes of the word being collected
   logic [4:0]    zero_idx_ff, zero_idx_in;
   logic [5:0]    rnd_ff, rnd_in;

   // block RAM: 16 message words, little-endian byte lanes
   logic          ram_we;
   logic [3:0]    ram_waddr;
   logic [31:0]   ram_wdata;
   logic [3:0]    ram_raddr;
   logic [31:0]   ram_rdata;

   logic [31:0]   round_out;
   logic [5:0]    pos;
   logic [1:0]    lane;
   logic          accept;
   logic          slot_free;
   logic [31:0]   acc_word;
   logic [31:0]   pad_word;

   assign pos       = bit_count_ff[8:3];
   assign lane      = pos[1:0];
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign acc_word  = {8'h00, acc_ff};

   // word holding the pad byte: collected bytes, then 0x80, then zeros
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         if (2'(j) < lane) begin
            pad_word[8*j +: 8] = acc_word[8*j +: 8];
         end else if (2'(j) == lane) begin
            pad_word[8*j +: 8] = PAD_BYTE;
         end else begin
            pad_word[8*j +: 8] = 8'h00;
         end
      end
   end

   md5_ram #(
      .WIDTH (32),
      .DEPTH (16)
   ) u_block_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   md5_round u_round (
      .work     (work_ff),
      .rnd      (rnd_ff),
      .msg_word (ram_rdata),
      .new_b    (round_out)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_FINISH) begin
                  state_in = ST_ZERO;
               end else if (pos == 6'd63) begin
                  state_in = ST_PRIME;
               end
            end
         end
         ST_ZERO: begin
            if (zero_idx_ff[4] || zero_idx_ff[3:0] == 4'd15) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (fin_ff) begin
               state_in = two_ff ? ST_ZERO : ST_OUT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      fin_in       = fin_ff;
      two_in       = two_ff;
      chain_in     = chain_ff;
      bit_count_in = bit_count_ff;
      work_in      = work_ff;
      digest_in    = digest_ff;
      acc_in       = acc_ff;
      zero_idx_in  = zero_idx_ff;
      rnd_in       = rnd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we       = 1'b0;
      ram_waddr    = pos[5:2];
      ram_wdata    = 32'h0;
      ram_raddr    = (state_ff == ST_ROUND) ? msg_index(rnd_ff + 6'd1) : msg_index(6'd0);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_ABSORB) begin
                  bit_count_in = bit_count_ff + 64'd8;
                  if (lane == 2'd3) begin
                     ram_we    = 1'b1;
                     ram_wdata = {req_data_byte, acc_ff};
                  end else begin
                     acc_in[{lane, 3'b000} +: 8] = req_data_byte;
                  end
               end else begin
                  ram_we      = 1'b1;
                  ram_wdata   = pad_word;
                  fin_in      = 1'b1;
                  two_in      = (pos[5:3] == 3'b111);
                  zero_idx_in = {1'b0, pos[5:2]} + 5'd1;
               end
            end
         end
         ST_ZERO: begin
            // final block carries the bit count in words 14 and 15
            if (!zero_idx_ff[4]) begin
               ram_we      = 1'b1;
               ram_waddr   = zero_idx_ff[3:0];
               zero_idx_in = zero_idx_ff + 5'd1;
               if (!two_ff && zero_idx_ff[3:0] == 4'd14) begin
                  ram_wdata = bit_count_ff[31:0];
               end else if (!two_ff && zero_idx_ff[3:0] == 4'd15) begin
                  ram_wdata = bit_count_ff[63:32];
               end
            end
         end
         ST_PRIME: begin
            work_in = chain_ff;
            rnd_in  = 6'd0;
         end
         ST_ROUND: begin
            work_in.a = work_ff.d;
            work_in.b = round_out;
            work_in.c = work_ff.b;
            work_in.d = work_ff.c;
            rnd_in    = rnd_ff + 6'd1;
         end
         ST_ADD: begin
            chain_in.a = chain_ff.a + work_ff.a;
            chain_in.b = chain_ff.b + work_ff.b;
            chain_in.c = chain_ff.c + work_ff.c;
            chain_in.d = chain_ff.d + work_ff.d;
            if (fin_ff && two_ff) begin
               two_in      = 1'b0;
               zero_idx_in = 5'd0;
            end
         end
         ST_OUT: begin
            if (slot_free) begin
               digest_in    = chain_ff;
               rsp_valid_in = 1'b1;
               chain_in     = CHAIN_INIT;
               bit_count_in = 64'd0;
               fin_in       = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fin_ff       <= 1'b0;
         two_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chain_ff     <= CHAIN_INIT;
         bit_count_ff <= 64'd0;
      end else begin
         state_ff     <= state_in;
         fin_ff       <= fin_in;
         two_ff       <= two_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_ff     <= chain_in;
         bit_count_ff <= bit_count_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      digest_ff   <= digest_in;
      acc_ff      <= acc_in;
      zero_idx_ff <= zero_idx_in;
      rnd_ff      <= rnd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digest_word0 = digest_ff.a;
   assign rsp_digest_word1 = digest_ff.b;
   assign rsp_digest_word2 = digest_ff.c;
   assign rsp_digest_word3 = digest_ff.d;

`ifndef SYNTHESIS
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("digest appeared outside the output step");

   a_no_write_in_compress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRIME || state_ff == ST_ROUND) |-> !ram_we)
      else $error("block RAM written during compression");

   a_restart_after_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && slot_free) |=> (bit_count_ff == 64'd0 && !fin_ff))
      else $error("hash state not restarted after digest");

   a_extra_block_in_finish: assert property (@(posedge clock) disable iff (reset)
      two_ff |-> fin_ff)
      else $error("extra padding block outside a finish");
`endif

endmodule
